>>> src/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg
// shared types, token codes and keyword patterns of the token scanner
// ----------------------------------------------------------------------------
package sts_pkg;

	localparam int LINE_BITS   = 16;
	localparam int COLUMN_BITS = 12;
	localparam int LEN_BITS    = 12;
	localparam int TYPE_BITS   = 5;
	localparam int NUM_KW      = 8;
	localparam int KW_BYTES    = 6;
	localparam int FIFO_DEPTH  = 8;
	localparam int PTR_BITS    = $clog2(FIFO_DEPTH);

	localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};
	localparam logic [COLUMN_BITS-1:0] COL_MAX  = {COLUMN_BITS{1'b1}};
	localparam logic [LEN_BITS-1:0]    LEN_MAX  = {LEN_BITS{1'b1}};

	// token codes
	localparam logic [TYPE_BITS-1:0] T_KW_FIRST = 5'd0;
	localparam logic [TYPE_BITS-1:0] T_IDENT    = 5'd8;
	localparam logic [TYPE_BITS-1:0] T_PLUS     = 5'd9;
	localparam logic [TYPE_BITS-1:0] T_MINUS    = 5'd10;
	localparam logic [TYPE_BITS-1:0] T_STAR     = 5'd11;
	localparam logic [TYPE_BITS-1:0] T_SLASH    = 5'd12;
	localparam logic [TYPE_BITS-1:0] T_ASSIGN   = 5'd13;
	localparam logic [TYPE_BITS-1:0] T_EQ       = 5'd14;
	localparam logic [TYPE_BITS-1:0] T_NE       = 5'd15;
	localparam logic [TYPE_BITS-1:0] T_LT       = 5'd16;
	localparam logic [TYPE_BITS-1:0] T_GT       = 5'd17;
	localparam logic [TYPE_BITS-1:0] T_LE       = 5'd18;
	localparam logic [TYPE_BITS-1:0] T_GE       = 5'd19;
	localparam logic [TYPE_BITS-1:0] T_LPAREN   = 5'd20;
	localparam logic [TYPE_BITS-1:0] T_RPAREN   = 5'd21;
	localparam logic [TYPE_BITS-1:0] T_LBRACE   = 5'd22;
	localparam logic [TYPE_BITS-1:0] T_RBRACE   = 5'd23;
	localparam logic [TYPE_BITS-1:0] T_ARROW    = 5'd24;
	localparam logic [TYPE_BITS-1:0] T_COMMA    = 5'd25;
	localparam logic [TYPE_BITS-1:0] T_COLON    = 5'd26;
	localparam logic [TYPE_BITS-1:0] T_SEMI     = 5'd27;
	localparam logic [TYPE_BITS-1:0] T_INT      = 5'd28;
	localparam logic [TYPE_BITS-1:0] T_DOUBLE   = 5'd29;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_DIGIT   = 2'd2,
		ST_EOL     = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		M_IDLE, M_COMMENT, M_MINUS, M_SLASH, M_EQ, M_BANG, M_LT, M_GT,
		M_INT, M_DOT, M_FRAC, M_EXP, M_EXP_WS, M_EXP_SIGN, M_EXP_DIG, M_IDENT
	} mode_t;

	// keywords, first byte in the low byte, zero padded
	localparam logic [8*KW_BYTES-1:0] KW_PAT [NUM_KW] = '{
		48'h0000_0000_6e66,   // fn
		48'h0000_0074_656c,   // let
		48'h0074_736e_6f63,   // const
		48'h0000_0000_7361,   // as
		48'h0065_6c69_6877,   // while
		48'h0000_0000_6669,   // if
		48'h0000_6573_6c65,   // else
		48'h6e72_7574_6572    // return
	};

	typedef struct packed {
		mode_t                  mode;
		logic [8*KW_BYTES-1:0]  kbuf;
		logic [LEN_BITS-1:0]    len;
		logic [COLUMN_BITS-1:0] scol;
		logic [COLUMN_BITS-1:0] ccol;
		logic [LINE_BITS-1:0]   line;
		logic                   halted;
	} scan_st_t;

	typedef struct packed {
		logic [TYPE_BITS-1:0]   token_type;
		logic [LINE_BITS-1:0]   line;
		logic [COLUMN_BITS-1:0] column;
		logic [LEN_BITS-1:0]    length;
		logic [1:0]             status;
		logic                   last_of_run;
	} res_t;

	typedef struct packed {
		scan_st_t   s;
		res_t       r0;
		res_t       r1;
		logic [1:0] n;
	} work_t;

endpackage

>>> src/sts_if.sv
// ----------------------------------------------------------------------------
// sts_if
// byte channel into the scanner and token channel out of it
// ----------------------------------------------------------------------------
interface sts_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_req;
	logic       end_of_stream;

	modport source (output valid, output byte_req, output end_of_stream, input ready);
	modport sink   (input valid, input byte_req, input end_of_stream, output ready);
endinterface

interface sts_out_if;
	logic        valid;
	logic        ready;
	logic [4:0]  token_type;
	logic [15:0] line;
	logic [11:0] column;
	logic [11:0] length;
	logic [1:0]  status;
	logic        last_of_run;

	modport source (output valid, output token_type, output line, output column,
		output length, output status, output last_of_run, input ready);
	modport sink   (input valid, input token_type, input line, input column,
		input length, input status, input last_of_run, output ready);
endinterface

>>> src/sts_step.sv
// ----------------------------------------------------------------------------
// sts_step
// one byte of scanning: next state and up to two token items
// ----------------------------------------------------------------------------
module sts_step (
	input  sts_pkg::scan_st_t st,
	input  logic              vld,
	input  logic [7:0]        byte_req,
	input  logic              end_of_stream,
	output sts_pkg::work_t    wo
);
	import sts_pkg::*;

	function automatic logic is_digit(logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic logic is_letter(logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
	endfunction

	function automatic logic is_space(logic [7:0] b);
		return b == " " || (b >= 8'd9 && b <= 8'd13);
	endfunction

	function automatic logic [COLUMN_BITS-1:0] here_col(scan_st_t s);
		return (s.ccol == COL_MAX) ? COL_MAX : s.ccol + 1'b1;
	endfunction

	function automatic logic [COLUMN_BITS-1:0] end_col(scan_st_t s);
		logic [24:0] sum;
		sum = 25'(s.scol) + 25'(s.len);
		return (sum > 25'(COL_MAX)) ? COL_MAX : sum[COLUMN_BITS-1:0];
	endfunction

	function automatic work_t emit(work_t w, logic [TYPE_BITS-1:0] ty,
		logic [COLUMN_BITS-1:0] col, logic [LEN_BITS-1:0] len, status_t stat);
		res_t r;
		r.token_type  = ty;
		r.line        = w.s.line;
		r.column      = col;
		r.length      = len;
		r.status      = stat;
		r.last_of_run = 1'b0;
		if (w.n == 2'd0) w.r0 = r;
		else if (w.n == 2'd1) w.r1 = r;
		if (w.n != 2'd2) w.n = w.n + 2'd1;
		return w;
	endfunction

	function automatic work_t emit_tok(work_t w, logic [TYPE_BITS-1:0] ty);
		return emit(w, ty, w.s.scol, w.s.len, ST_OK);
	endfunction

	function automatic work_t fail(work_t w, status_t stat, logic [COLUMN_BITS-1:0] col);
		w = emit(w, T_KW_FIRST, col, '0, stat);
		w.s.halted = 1'b1;
		w.s.mode   = M_IDLE;
		return w;
	endfunction

	function automatic logic [TYPE_BITS-1:0] ident_type(scan_st_t s);
		logic [TYPE_BITS-1:0] ty;
		ty = T_IDENT;
		if (s.len <= LEN_BITS'(KW_BYTES))
			for (int k = NUM_KW - 1; k >= 0; k--)
				if (s.kbuf == KW_PAT[k]) ty = TYPE_BITS'(k);
		return ty;
	endfunction

	function automatic work_t grow(work_t w);
		if (w.s.len != LEN_MAX) w.s.len = w.s.len + 1'b1;
		return w;
	endfunction

	function automatic work_t start(work_t w, mode_t m);
		w.s.mode = m;
		w.s.scol = here_col(w.s);
		w.s.len  = LEN_BITS'(1);
		return w;
	endfunction

	function automatic work_t idle_byte(work_t w, logic [7:0] b);
		logic [TYPE_BITS-1:0] single;
		single = '0;
		case (b)
			"+":     single = T_PLUS;
			"*":     single = T_STAR;
			"(":     single = T_LPAREN;
			")":     single = T_RPAREN;
			"{":     single = T_LBRACE;
			"}":     single = T_RBRACE;
			",":     single = T_COMMA;
			":":     single = T_COLON;
			";":     single = T_SEMI;
			default: single = '0;
		endcase
		if (single != '0) begin
			w = start(w, M_IDLE);
			w = emit_tok(w, single);
		end else if (b == "-") w = start(w, M_MINUS);
		else if (b == "/") w = start(w, M_SLASH);
		else if (b == "=") w = start(w, M_EQ);
		else if (b == "!") w = start(w, M_BANG);
		else if (b == "<") w = start(w, M_LT);
		else if (b == ">") w = start(w, M_GT);
		else if (is_space(b)) begin
		end else if (is_digit(b)) w = start(w, M_INT);
		else if (is_letter(b) || b == "_") begin
			w = start(w, M_IDENT);
			w.s.kbuf = 48'(b);
		end else w = fail(w, ST_INVALID, here_col(w.s));
		return w;
	endfunction

	function automatic work_t redo(work_t w, logic [TYPE_BITS-1:0] ty, logic [7:0] b);
		w = emit_tok(w, ty);
		w.s.mode = M_IDLE;
		return idle_byte(w, b);
	endfunction

	function automatic work_t two_char(work_t w, logic [7:0] b, logic [7:0] want,
		logic [TYPE_BITS-1:0] pair, logic [TYPE_BITS-1:0] lone);
		if (b == want) begin
			w.s.len  = LEN_BITS'(2);
			w        = emit_tok(w, pair);
			w.s.mode = M_IDLE;
		end else w = redo(w, lone, b);
		return w;
	endfunction

	function automatic work_t flush(work_t w);
		case (w.s.mode)
			M_MINUS:             w = emit_tok(w, T_MINUS);
			M_SLASH:             w = emit_tok(w, T_SLASH);
			M_EQ:                w = emit_tok(w, T_ASSIGN);
			M_LT:                w = emit_tok(w, T_LT);
			M_GT:                w = emit_tok(w, T_GT);
			M_BANG:              w = fail(w, ST_INVALID, w.s.scol);
			M_INT:               w = emit_tok(w, T_INT);
			M_DOT:               w = fail(w, ST_DIGIT, here_col(w.s));
			M_FRAC, M_EXP_DIG:   w = emit_tok(w, T_DOUBLE);
			M_EXP, M_EXP_WS:     w = fail(w, ST_EOL, end_col(w.s));
			M_EXP_SIGN:          w = fail(w, ST_DIGIT, here_col(w.s));
			M_IDENT:             w = emit_tok(w, ident_type(w.s));
			default: begin
			end
		endcase
		w.s.mode = M_IDLE;
		return w;
	endfunction

	function automatic work_t line_byte(work_t w, logic [7:0] b);
		case (w.s.mode)
			M_IDLE:    w = idle_byte(w, b);
			M_MINUS:   w = two_char(w, b, ">", T_ARROW, T_MINUS);
			M_EQ:      w = two_char(w, b, "=", T_EQ, T_ASSIGN);
			M_LT:      w = two_char(w, b, "=", T_LE, T_LT);
			M_GT:      w = two_char(w, b, "=", T_GE, T_GT);
			M_SLASH:
				if (b == "/") w.s.mode = M_COMMENT;
				else w = redo(w, T_SLASH, b);
			M_BANG:
				if (b == "=") begin
					w.s.len  = LEN_BITS'(2);
					w        = emit_tok(w, T_NE);
					w.s.mode = M_IDLE;
				end else w = fail(w, ST_INVALID, w.s.scol);
			M_INT:
				if (is_digit(b)) w = grow(w);
				else if (b == ".") begin
					w = grow(w);
					w.s.mode = M_DOT;
				end else w = redo(w, T_INT, b);
			M_DOT:
				if (is_digit(b)) begin
					w = grow(w);
					w.s.mode = M_FRAC;
				end else w = fail(w, ST_DIGIT, here_col(w.s));
			M_FRAC:
				if (is_digit(b)) w = grow(w);
				else if (b == "e" || b == "E") begin
					w = grow(w);
					w.s.mode = M_EXP;
				end else w = redo(w, T_DOUBLE, b);
			M_EXP:
				if (b == "+" || b == "-") begin
					w = grow(w);
					w.s.mode = M_EXP_SIGN;
				end else if (is_digit(b)) begin
					w = grow(w);
					w.s.mode = M_EXP_DIG;
				end else if (is_space(b)) w.s.mode = M_EXP_WS;
				else w = fail(w, ST_DIGIT, here_col(w.s));
			M_EXP_WS:
				if (!is_space(b)) w = fail(w, ST_DIGIT, end_col(w.s));
			M_EXP_SIGN:
				if (is_digit(b)) begin
					w = grow(w);
					w.s.mode = M_EXP_DIG;
				end else w = fail(w, ST_DIGIT, here_col(w.s));
			M_EXP_DIG:
				if (is_digit(b)) w = grow(w);
				else w = redo(w, T_DOUBLE, b);
			M_IDENT:
				if (is_letter(b) || is_digit(b) || b == "_") begin
					if (w.s.len < LEN_BITS'(KW_BYTES))
						w.s.kbuf[8*w.s.len[2:0] +: 8] = b;
					w = grow(w);
				end else w = redo(w, ident_type(w.s), b);
			default: begin
			end
		endcase
		return w;
	endfunction

	always_comb begin
		wo   = '0;
		wo.s = st;
		if (vld && !st.halted) begin
			if (byte_req == 8'd10) begin
				wo = flush(wo);
				if (!wo.s.halted) begin
					if (wo.s.line != LINE_MAX) wo.s.line = wo.s.line + 1'b1;
					wo.s.ccol = '0;
				end
			end else begin
				wo = line_byte(wo, byte_req);
				if (wo.s.ccol != COL_MAX) wo.s.ccol = wo.s.ccol + 1'b1;
			end
			if (end_of_stream && !wo.s.halted) wo = flush(wo);
			// mark the final item caused by this byte
			if (wo.n == 2'd1) wo.r0.last_of_run = 1'b1;
			if (wo.n == 2'd2) wo.r1.last_of_run = 1'b1;
		end
	end

endmodule

>>> src/source_token_scanner.sv
// path: a byte accepted goes into the input register and is scanned from there; its token
//   items are written into the token queue, which offers them on the token channel
// throughput: one byte per cycle, while the token channel is ready and bytes average at most one token each
// an 8-entry token queue absorbs bytes that cause two tokens; bytes are held
//   off when the queue could not take two more from each byte in flight
// reset: scanner idle between tokens, line 1, column 0, queue empty
// ----------------------------------------------------------------------------
// source_token_scanner
// streaming lexer: bytes in, one token item per lexeme out
// ----------------------------------------------------------------------------
module source_token_scanner (
	input  logic      clk,
	input  logic      arst_n,
	sts_in_if.sink    src_ch,
	sts_out_if.source tok_ch
);
	import sts_pkg::*;

	// input register
	logic       v_s1;
	logic [7:0] byte_s1;
	logic       eos_s1;

	// scanner state
	scan_st_t st_q;
	work_t    step_w;

	// token queue
	res_t                fifo_q [FIFO_DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [PTR_BITS:0]   cnt_q;
	logic                pop;
	logic [PTR_BITS+1:0] room_need;

	// room for two items from the byte in the input register and two more
	assign room_need    = {1'b0, cnt_q} + (v_s1 ? (PTR_BITS+2)'(4) : (PTR_BITS+2)'(2));
	assign src_ch.ready = room_need <= (PTR_BITS+2)'(FIFO_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= src_ch.valid && src_ch.ready;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (src_ch.valid && src_ch.ready) begin
			byte_s1 <= src_ch.byte_req;
			eos_s1  <= src_ch.end_of_stream;
		end
	end

	sts_step u_step (
		.st            (st_q),
		.vld           (v_s1),
		.byte_req      (byte_s1),
		.end_of_stream (eos_s1),
		.wo            (step_w)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.mode   <= M_IDLE;
			st_q.kbuf   <= '0;
			st_q.len    <= '0;
			st_q.scol   <= '0;
			st_q.ccol   <= '0;
			st_q.line   <= LINE_BITS'(1);
			st_q.halted <= 1'b0;
		end else if (v_s1) begin
			st_q <= step_w.s;
		end
	end

	// queue: up to two writes, one read a cycle
	assign pop = tok_ch.valid && tok_ch.ready;

	always_ff @(posedge clk) begin
		if (v_s1 && step_w.n != 2'd0) fifo_q[wr_ptr_q] <= step_w.r0;
		if (v_s1 && step_w.n == 2'd2) fifo_q[wr_ptr_q + 1'b1] <= step_w.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (v_s1) wr_ptr_q <= wr_ptr_q + PTR_BITS'(step_w.n);
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			cnt_q <= cnt_q + (v_s1 ? (PTR_BITS+1)'(step_w.n) : '0)
				- (PTR_BITS+1)'(pop);
		end
	end

	assign tok_ch.valid       = cnt_q != '0;
	assign tok_ch.token_type  = fifo_q[rd_ptr_q].token_type;
	assign tok_ch.line        = fifo_q[rd_ptr_q].line;
	assign tok_ch.column      = fifo_q[rd_ptr_q].column;
	assign tok_ch.length      = fifo_q[rd_ptr_q].length;
	assign tok_ch.status      = fifo_q[rd_ptr_q].status;
	assign tok_ch.last_of_run = fifo_q[rd_ptr_q].last_of_run;

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> ({1'b0, cnt_q} + (PTR_BITS+2)'(step_w.n) <= (PTR_BITS+2)'(FIFO_DEPTH)))
		else $error("token queue overflow");
	a_halt_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.halted |=> st_q.halted)
		else $error("scanner left halt without reset");
	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && st_q.halted) |-> step_w.n == 2'd0)
		else $error("token item produced while halted");
	a_error_halts: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && step_w.n != 2'd0 && step_w.r0.status != ST_OK) |-> step_w.s.halted)
		else $error("error item without halt");
`endif

endmodule
